// ===== hdl/hrbc_pkg.sv =====
// ----------------------------------------------------------------------------
// hrbc_pkg
// Shared types, codes and constants of the HTTP request byte classifier.
// ----------------------------------------------------------------------------
package hrbc_pkg;

    // Header lines the block can count before the overflow error is raised.
    localparam int HEADER_SLOTS        = 32;
    localparam int LINE_COUNT_BITS_DEF = 16;

    localparam int HDR_CNT_W = 6;
    localparam int HDR_IDX_W = 5;
    localparam int LEN_W     = 16;

    localparam logic [HDR_CNT_W-1:0] MAX_HEADERS_RST = 6'd32;

    // Configuration register index.
    localparam logic REG_MAX_HEADERS = 1'b0;

    // Byte values of interest.
    localparam logic [7:0] CHR_CR  = 8'h0D;
    localparam logic [7:0] CHR_LF  = 8'h0A;
    localparam logic [7:0] CHR_SP  = 8'h20;
    localparam logic [7:0] CHR_NUL = 8'h00;

    // Byte classes.
    localparam logic [2:0] KIND_METHOD  = 3'd0;
    localparam logic [2:0] KIND_PATH    = 3'd1;
    localparam logic [2:0] KIND_VERSION = 3'd2;
    localparam logic [2:0] KIND_EXTRA   = 3'd3;
    localparam logic [2:0] KIND_SPACE   = 3'd4;
    localparam logic [2:0] KIND_CRLF    = 3'd5;
    localparam logic [2:0] KIND_HEADER  = 3'd6;
    localparam logic [2:0] KIND_BODY    = 3'd7;

    // Error codes.
    localparam logic [1:0] ERR_NONE      = 2'd0;
    localparam logic [1:0] ERR_TRUNCATED = 2'd1;
    localparam logic [1:0] ERR_OVERFLOW  = 2'd2;

    typedef enum logic [1:0] {
        SEC_REQLINE,
        SEC_HEADERS,
        SEC_BODY
    } sec_t;

    // Parser state, apart from the line counter whose width is a parameter.
    typedef struct packed {
        sec_t                 section;
        logic                 cr_pending;
        logic [1:0]           space_count;
        logic [HDR_CNT_W-1:0] headers_seen;
    } hrbc_state_t;

    typedef struct packed {
        logic [2:0]           byte_kind;
        logic [HDR_IDX_W-1:0] header_index;
        logic                 line_end;
        logic [LEN_W-1:0]     line_length;
        logic                 headers_done;
        logic [HDR_CNT_W-1:0] header_count;
        logic [1:0]           error_code;
        logic                 last_result;
    } hrbc_result_t;

endpackage

// ===== hdl/hrbc_if.sv =====
// ----------------------------------------------------------------------------
// hrbc_if
// Valid/ready channels of the classifier: request bytes in, results out.
// ----------------------------------------------------------------------------
interface hrbc_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       last_byte;

    modport source (output valid, output data_byte, output last_byte, input ready);
    modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

interface hrbc_out_if;
    logic        valid;
    logic        ready;
    logic [2:0]  byte_kind;
    logic [4:0]  header_index;
    logic        line_end;
    logic [15:0] line_length;
    logic        headers_done;
    logic [5:0]  header_count;
    logic [1:0]  error_code;
    logic        last_result;

    modport source (
        output valid, output byte_kind, output header_index, output line_end,
        output line_length, output headers_done, output header_count,
        output error_code, output last_result, input ready
    );
    modport sink (
        input valid, input byte_kind, input header_index, input line_end,
        input line_length, input headers_done, input header_count,
        input error_code, input last_result, output ready
    );
endinterface

// ===== hdl/hrbc_step.sv =====
// ----------------------------------------------------------------------------
// hrbc_step
// Classify one byte against the current parser state and form the next state.
// ----------------------------------------------------------------------------
module hrbc_step
    import hrbc_pkg::*;
#(
    parameter int LINE_COUNT_BITS = LINE_COUNT_BITS_DEF
)
(
    input  hrbc_state_t                state_cur,
    input  logic [LINE_COUNT_BITS-1:0] line_cnt_cur,
    input  logic [HDR_CNT_W-1:0]       limit,
    input  logic [7:0]                 data_byte,
    input  logic                       last_byte,
    output hrbc_state_t                state_nxt,
    output logic [LINE_COUNT_BITS-1:0] line_cnt_nxt,
    output hrbc_result_t               result
);

    localparam int WIDE_W = (LINE_COUNT_BITS > LEN_W) ? LINE_COUNT_BITS : LEN_W;
    localparam logic [WIDE_W-1:0] LEN_SAT = WIDE_W'({LEN_W{1'b1}});

    logic [WIDE_W-1:0] cnt_wide;
    logic [LEN_W-1:0]  len_sat;
    logic              is_cr;
    logic              is_lf;
    logic              is_sep;

    assign cnt_wide = WIDE_W'(line_cnt_cur);
    assign len_sat  = (cnt_wide > LEN_SAT) ? {LEN_W{1'b1}} : cnt_wide[LEN_W-1:0];
    assign is_cr    = (data_byte == CHR_CR);
    assign is_lf    = (data_byte == CHR_LF);
    assign is_sep   = (data_byte == CHR_SP) || (data_byte == CHR_NUL);

    always_comb
    begin
        state_nxt    = state_cur;
        line_cnt_nxt = line_cnt_cur;
        result       = '0;

        if (state_cur.section == SEC_BODY)
        begin
            result.byte_kind = KIND_BODY;
        end
        else if (is_cr || is_lf)
        begin
            result.byte_kind = KIND_CRLF;
            if (is_cr)
            begin
                state_nxt.cr_pending = 1'b1;
            end
            else
            begin
                if (state_cur.cr_pending)
                begin
                    result.line_end    = 1'b1;
                    result.line_length = len_sat;
                    case (state_cur.section)
                        SEC_REQLINE:
                        begin
                            state_nxt.section = SEC_HEADERS;
                        end
                        SEC_HEADERS:
                        begin
                            if (line_cnt_cur == '0)
                            begin
                                result.headers_done = 1'b1;
                                state_nxt.section   = SEC_BODY;
                            end
                            else if (state_cur.headers_seen >= limit)
                            begin
                                result.error_code      = ERR_OVERFLOW;
                                state_nxt.headers_seen = limit;
                            end
                            else
                            begin
                                state_nxt.headers_seen = state_cur.headers_seen + 1'b1;
                            end
                        end
                        default:
                        begin
                            state_nxt.section = state_cur.section;
                        end
                    endcase
                    line_cnt_nxt = '0;
                end
                state_nxt.cr_pending = 1'b0;
            end
        end
        else
        begin
            state_nxt.cr_pending = 1'b0;
            if (line_cnt_cur != {LINE_COUNT_BITS{1'b1}})
            begin
                line_cnt_nxt = line_cnt_cur + 1'b1;
            end
            if (state_cur.section == SEC_REQLINE)
            begin
                if (is_sep)
                begin
                    result.byte_kind = KIND_SPACE;
                    if (state_cur.space_count != 2'd3)
                    begin
                        state_nxt.space_count = state_cur.space_count + 1'b1;
                    end
                end
                else
                begin
                    result.byte_kind = 3'(state_cur.space_count);
                end
            end
            else
            begin
                result.byte_kind    = KIND_HEADER;
                result.header_index = (state_cur.headers_seen > 6'd31) ?
                                      5'd31 : state_cur.headers_seen[HDR_IDX_W-1:0];
            end
        end

        // Truncated request wins over overflow.
        if (last_byte && (state_nxt.section != SEC_BODY))
        begin
            result.error_code = ERR_TRUNCATED;
        end

        result.header_count = state_nxt.headers_seen;
        result.last_result  = last_byte;

        if (last_byte)
        begin
            state_nxt    = '{section: SEC_REQLINE, cr_pending: 1'b0,
                             space_count: 2'd0, headers_seen: '0};
            line_cnt_nxt = '0;
        end
    end

endmodule

// ===== hdl/http_request_byte_classifier_unit.sv =====
// ----------------------------------------------------------------------------
// http_request_byte_classifier_unit
// Streaming classifier of HTTP request bytes with an APB limit register.
// ----------------------------------------------------------------------------
// Feed the bytes of one request, one per transaction, with last_byte set on
// the final byte; every byte yields exactly one result transaction, in order.
// Unless results stall, the block takes one byte per clock cycle; each result
// appears in the cycle after its byte is accepted: the classification of a byte
// and the update of the parser state sit in a single level of logic in front of
// the result register. The result register doubles as the output buffer, so a
// new byte is accepted in the same cycle that the waiting result is taken. After
// the byte marked last, the parser returns to the request-line state. The
// max_headers register (address 0) limits the header lines counted; write it
// only while no result is outstanding.
module http_request_byte_classifier_unit
    import hrbc_pkg::*;
#(
    parameter int LINE_COUNT_BITS = LINE_COUNT_BITS_DEF
)
(
    input  logic              clk,
    input  logic              rst_n,
    // Configuration port
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [2:0]        paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready,
    // Streams
    hrbc_in_if.sink           req_in,
    hrbc_out_if.source        res_out
);

    // ------------------------------------------------------------------
    // Configuration register
    // ------------------------------------------------------------------
    logic [HDR_CNT_W-1:0] max_headers_reg;
    logic                 cfg_write;
    logic [HDR_CNT_W-1:0] limit;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready && (paddr[2] == REG_MAX_HEADERS);
    assign prdata    = (paddr[2] == REG_MAX_HEADERS) ? 32'(max_headers_reg) : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_headers_reg <= MAX_HEADERS_RST;
        end
        else if (cfg_write)
        begin
            max_headers_reg <= pwdata[HDR_CNT_W-1:0];
        end
    end

    // Effective limit is the smaller of the register and the slot count.
    assign limit = (max_headers_reg < HDR_CNT_W'(HEADER_SLOTS)) ?
                   max_headers_reg : HDR_CNT_W'(HEADER_SLOTS);

    // ------------------------------------------------------------------
    // Parser state and classification
    // ------------------------------------------------------------------
    hrbc_state_t                state_reg;
    hrbc_state_t                state_next;
    logic [LINE_COUNT_BITS-1:0] line_cnt_reg;
    logic [LINE_COUNT_BITS-1:0] line_cnt_next;
    hrbc_result_t               result_next;
    hrbc_result_t               result_reg;
    logic                       res_valid_reg;
    logic                       in_accept;

    hrbc_step #(
        .LINE_COUNT_BITS (LINE_COUNT_BITS)
    ) u_step (
        .state_cur    (state_reg),
        .line_cnt_cur (line_cnt_reg),
        .limit        (limit),
        .data_byte    (req_in.data_byte),
        .last_byte    (req_in.last_byte),
        .state_nxt    (state_next),
        .line_cnt_nxt (line_cnt_next),
        .result       (result_next)
    );

    // Accept whenever the result slot is empty or is being drained.
    assign req_in.ready = !res_valid_reg || res_out.ready;
    assign in_accept    = req_in.valid && req_in.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= '{section: SEC_REQLINE, cr_pending: 1'b0,
                               space_count: 2'd0, headers_seen: '0};
            line_cnt_reg  <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_accept)
            begin
                state_reg    <= state_next;
                line_cnt_reg <= line_cnt_next;
            end
            // Hold the result until taken; advance on every accepted byte.
            if (in_accept)
            begin
                res_valid_reg <= 1'b1;
            end
            else if (res_out.ready)
            begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            result_reg <= result_next;
        end
    end

    // ------------------------------------------------------------------
    // Result channel
    // ------------------------------------------------------------------
    assign res_out.valid        = res_valid_reg;
    assign res_out.byte_kind    = result_reg.byte_kind;
    assign res_out.header_index = result_reg.header_index;
    assign res_out.line_end     = result_reg.line_end;
    assign res_out.line_length  = result_reg.line_length;
    assign res_out.headers_done = result_reg.headers_done;
    assign res_out.header_count = result_reg.header_count;
    assign res_out.error_code   = result_reg.error_code;
    assign res_out.last_result  = result_reg.last_result;

`ifndef ASSERT_OFF
    // A completed line is always reported on an LF byte.
    a_line_end_kind: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid_reg && result_reg.line_end |-> result_reg.byte_kind == KIND_CRLF)
        else $error("line end reported on a non-terminator byte");

    // Closing the headers and overflowing both happen only at a line end.
    a_done_on_end: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid_reg && (result_reg.headers_done ||
                          result_reg.error_code == ERR_OVERFLOW)
        |-> result_reg.line_end)
        else $error("header close or overflow without a line end");

    // The final byte of a request puts the parser back to the request line.
    a_last_clears: assert property (@(posedge clk) disable iff (!rst_n)
        in_accept && req_in.last_byte |=>
        state_reg.section == SEC_REQLINE && state_reg.headers_seen == '0 &&
        line_cnt_reg == '0 && !state_reg.cr_pending)
        else $error("parser state not cleared after last byte");

    // The header count never exceeds the slot count.
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg.headers_seen <= HDR_CNT_W'(HEADER_SLOTS))
        else $error("header count beyond slot count");

    // A stalled result is not overwritten.
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid_reg && !res_out.ready |-> !in_accept)
        else $error("byte accepted while result slot is full");
`endif

endmodule
